// File: src/sebd_pkg.sv
// Shared constants, codes and types for the sharded embedding dequant block.
// No dependencies; every other source file but sebd_ifs.sv imports this package.
package sebd_pkg;

   localparam int BLOCK_SIZE           = 32;
   localparam int BLOCK_SHIFT          = $clog2(BLOCK_SIZE);
   localparam int MAX_ROW_LENGTH       = 8192;
   localparam int TABLE_BLOCKS_DEFAULT = 65536;
   localparam int GROUP_BITS           = 2;

   localparam logic [13:0] ROW_LENGTH_RESET = 14'd4096;
   localparam logic [31:0] QNAN_BITS        = 32'h7FC0_0000;

   typedef enum logic [1:0] {
      CMD_HEADER = 2'd0,
      CMD_CODES  = 2'd1,
      CMD_LOOKUP = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_SHARD_OFFSET = 2'd0,
      CSR_SHARD_ROWS   = 2'd1,
      CSR_ROW_LENGTH   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [19:0] shard_offset;
      logic [16:0] shard_rows;
      logic [13:0] row_length;
   } cfg_type;

   // One element issued into the dequant pipeline
   typedef struct packed {
      logic        valid;
      logic        outside;
      logic        last;
      logic [12:0] index;
      logic [2:0]  byte_sel;
   } elem_type;

   typedef struct packed {
      logic hdr_we;
      logic code_we;
   } mem_ctl_type;

endpackage

// File: src/sebd_ifs.sv
// Valid/ready channel interfaces: request items, result items and register writes.
// Standalone; no package dependency.
interface sebd_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [19:0] token_num;
   logic [7:0]  row_block;
   logic [15:0] block_addr;
   logic [1:0]  code_group;
   logic [15:0] scale_half;
   logic [15:0] minimum_half;
   logic [63:0] codes_word;

   modport source (output valid, cmd, token_num, row_block, block_addr, code_group,
                   scale_half, minimum_half, codes_word, input ready);
   modport sink (input valid, cmd, token_num, row_block, block_addr, code_group,
                 scale_half, minimum_half, codes_word, output ready);
endinterface

interface sebd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] value_bits;
   logic [12:0] element_index;
   logic        out_of_shard;
   logic        last_in_block;

   modport source (output valid, value_bits, element_index, out_of_shard, last_in_block,
                   input ready);
   modport sink (input valid, value_bits, element_index, out_of_shard, last_in_block,
                 output ready);
endinterface

interface sebd_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [19:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: src/sharded_embedding_block_dequant_top.sv
// A lookup passes stages f1 and f2, the element sequencer, the table read and p0 to p3 before
// its first result is registered. One result per cycle while results are not stalled; a lookup
// holds the element sequencer for its results (up to 32), a write or an empty lookup does not.
// Reset clears the shard registers (row_length to 4096) and all valid bits; the table
// memories are not cleared and read undefined until written.
module sharded_embedding_block_dequant_top import sebd_pkg::*; #(
   parameter int TABLE_BLOCKS = TABLE_BLOCKS_DEFAULT,
   localparam int AW = $clog2(TABLE_BLOCKS)
) (
   input  logic       clock,
   input  logic       reset,
   sebd_req_if.sink   req_if,
   sebd_rsp_if.source rsp_if,
   sebd_csr_if.sink   csr_if
);

   logic [19:0] shard_offset_ff;
   logic [16:0] shard_rows_ff;
   logic [13:0] row_length_ff;
   cfg_type     cfg;

   logic                     en;
   mem_ctl_type              mem_ctl;
   logic [AW-1:0]            hdr_addr;
   logic [AW+GROUP_BITS-1:0] code_addr;
   logic [31:0]              hdr_wdata;
   logic [63:0]              code_wdata;
   logic [31:0]              hdr_rdata;
   logic [63:0]              code_rdata;
   elem_type                 elem;

   assign csr_if.ready = 1'b1;

   // register writes; unknown index is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         shard_offset_ff <= '0;
         shard_rows_ff   <= '0;
         row_length_ff   <= ROW_LENGTH_RESET;
      end else if (csr_if.valid) begin
         case (csr_index_type'(csr_if.index))
            CSR_SHARD_OFFSET: shard_offset_ff <= csr_if.data;
            CSR_SHARD_ROWS:   shard_rows_ff   <= csr_if.data[16:0];
            CSR_ROW_LENGTH:   row_length_ff   <= csr_if.data[13:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.shard_offset = shard_offset_ff;
      cfg.shard_rows   = shard_rows_ff;
      cfg.row_length   = row_length_ff;
   end

   sebd_issue #(.TABLE_BLOCKS(TABLE_BLOCKS)) u_issue (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .cfg        (cfg),
      .req_if     (req_if),
      .mem_ctl    (mem_ctl),
      .hdr_addr   (hdr_addr),
      .code_addr  (code_addr),
      .hdr_wdata  (hdr_wdata),
      .code_wdata (code_wdata),
      .elem       (elem)
   );

   sebd_store #(.TABLE_BLOCKS(TABLE_BLOCKS)) u_store (
      .clock      (clock),
      .en         (en),
      .mem_ctl    (mem_ctl),
      .hdr_addr   (hdr_addr),
      .code_addr  (code_addr),
      .hdr_wdata  (hdr_wdata),
      .code_wdata (code_wdata),
      .hdr_rdata  (hdr_rdata),
      .code_rdata (code_rdata)
   );

   sebd_dequant u_dequant (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .elem       (elem),
      .hdr_rdata  (hdr_rdata),
      .code_rdata (code_rdata),
      .rsp_if     (rsp_if)
   );

`ifndef SYNTH
   // a table write never shares a cycle with an element read
   assert property (@(posedge clock) disable iff (reset)
      elem.valid |-> !(mem_ctl.hdr_we || mem_ctl.code_we))
      else $error("table write issued together with an element read");

   // a stalled result stalls intake
   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.ready) |-> !req_if.ready)
      else $error("request taken while result stalled");

   // out-of-shard results are positive zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.out_of_shard) |-> (rsp_if.value_bits == 32'd0))
      else $error("out-of-shard result not zero");
`endif

endmodule

// File: src/sebd_issue.sv
// Front end: shard/row checks, block address multiply and the per-element sequencer.
// Depends on sebd_pkg and sebd_req_if.
module sebd_issue import sebd_pkg::*; #(
   parameter int TABLE_BLOCKS = TABLE_BLOCKS_DEFAULT,
   localparam int AW = $clog2(TABLE_BLOCKS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  cfg_type                cfg,
   sebd_req_if.sink               req_if,
   output mem_ctl_type            mem_ctl,
   output logic [AW-1:0]          hdr_addr,
   output logic [AW+GROUP_BITS-1:0] code_addr,
   output logic [31:0]            hdr_wdata,
   output logic [63:0]            code_wdata,
   output elem_type               elem
);

   // accept-side decode
   logic [16:0] len_clamp;
   logic [13:0] len;
   logic [12:0] base;
   logic        in_row;
   logic [13:0] rem;
   logic [5:0]  count;
   logic [14:0] len_up;
   logic [20:0] diff;
   logic        outside;

   // first stage
   logic           f1_valid_ff;
   cmd_type        f1_cmd_ff;
   logic [AW-1:0]  f1_addr_ff;
   logic [1:0]     f1_group_ff;
   logic [31:0]    f1_hdr_ff;
   logic [63:0]    f1_codes_ff;
   logic           f1_outside_ff;
   logic           f1_in_row_ff;
   logic [5:0]     f1_count_ff;
   logic [12:0]    f1_base_ff;
   logic [15:0]    f1_local_ff;
   logic [7:0]     f1_rblk_ff;
   logic [9:0]     f1_bpr_ff;

   // second stage
   logic [25:0]    blk_prod;
   logic [26:0]    blk_sum;
   logic           f2_valid_ff;
   cmd_type        f2_cmd_ff;
   logic [AW-1:0]  f2_blk_ff;
   logic [1:0]     f2_group_ff;
   logic [31:0]    f2_hdr_ff;
   logic [63:0]    f2_codes_ff;
   logic           f2_outside_ff;
   logic           f2_emit_ff;
   logic [5:0]     f2_count_ff;
   logic [12:0]    f2_base_ff;

   // sequencer
   logic           s_active_ff;
   cmd_type        s_cmd_ff;
   logic [AW-1:0]  s_blk_ff;
   logic [1:0]     s_group_ff;
   logic [31:0]    s_hdr_ff;
   logic [63:0]    s_codes_ff;
   logic           s_outside_ff;
   logic           s_emit_ff;
   logic [5:0]     s_count_ff;
   logic [12:0]    s_base_ff;
   logic [4:0]     s_j_ff;

   logic s_lookup;
   logic s_last;
   logic s_done;
   logic f2_take;
   logic f1_take;

   // clamp row length, locate block in row, check the shard window
   always_comb begin
      len_clamp = ({3'b000, cfg.row_length} > 17'(MAX_ROW_LENGTH)) ?
                  17'(MAX_ROW_LENGTH) : {3'b000, cfg.row_length};
      len       = len_clamp[13:0];
      base      = 13'(req_if.row_block) << BLOCK_SHIFT;
      in_row    = {1'b0, base} < len;
      rem       = len - {1'b0, base};
      count     = (rem > 14'(BLOCK_SIZE)) ? 6'(BLOCK_SIZE) : rem[5:0];
      len_up    = {1'b0, len} + 15'(BLOCK_SIZE - 1);
      diff      = {1'b0, req_if.token_num} - {1'b0, cfg.shard_offset};
      outside   = diff[20] || (diff[19:0] >= {3'b000, cfg.shard_rows});
   end

   // block address of a lookup: local row times blocks per row plus block
   always_comb begin
      blk_prod = 26'(f1_local_ff) * 26'(f1_bpr_ff);
      blk_sum  = 27'(blk_prod) + 27'(f1_rblk_ff);
   end

   // sequencer status and stage handoff
   always_comb begin
      s_lookup = (s_cmd_ff == CMD_LOOKUP) && s_emit_ff;
      s_last   = ({1'b0, s_j_ff} + 6'd1) == s_count_ff;
      s_done   = !s_active_ff || !s_lookup || s_last;
      f2_take  = !f2_valid_ff || s_done;
      f1_take  = !f1_valid_ff || f2_take;
   end

   assign req_if.ready = en && f1_take;

   // valid bits of the three stages
   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         s_active_ff <= 1'b0;
      end else if (en) begin
         if (f1_take) begin
            f1_valid_ff <= req_if.valid;
         end
         if (f2_take) begin
            f2_valid_ff <= f1_valid_ff;
         end
         if (s_done) begin
            s_active_ff <= f2_valid_ff;
         end
      end
   end

   // stage payloads; advance with the valid bits
   always_ff @(posedge clock) begin
      if (en) begin
         if (f1_take) begin
            f1_cmd_ff     <= cmd_type'(req_if.cmd);
            f1_addr_ff    <= AW'(req_if.block_addr);
            f1_group_ff   <= req_if.code_group;
            f1_hdr_ff     <= {req_if.minimum_half, req_if.scale_half};
            f1_codes_ff   <= req_if.codes_word;
            f1_outside_ff <= outside;
            f1_in_row_ff  <= in_row;
            f1_count_ff   <= count;
            f1_base_ff    <= base;
            f1_local_ff   <= diff[15:0];
            f1_rblk_ff    <= req_if.row_block;
            f1_bpr_ff     <= len_up[BLOCK_SHIFT +: 10];
         end
         if (f2_take) begin
            f2_cmd_ff     <= f1_cmd_ff;
            f2_blk_ff     <= (f1_cmd_ff == CMD_LOOKUP) ? AW'(blk_sum) : f1_addr_ff;
            f2_group_ff   <= f1_group_ff;
            f2_hdr_ff     <= f1_hdr_ff;
            f2_codes_ff   <= f1_codes_ff;
            f2_outside_ff <= f1_outside_ff;
            f2_emit_ff    <= f1_in_row_ff;
            f2_count_ff   <= f1_count_ff;
            f2_base_ff    <= f1_base_ff;
         end
         if (s_done) begin
            s_cmd_ff     <= f2_cmd_ff;
            s_blk_ff     <= f2_blk_ff;
            s_group_ff   <= f2_group_ff;
            s_hdr_ff     <= f2_hdr_ff;
            s_codes_ff   <= f2_codes_ff;
            s_outside_ff <= f2_outside_ff;
            s_emit_ff    <= f2_emit_ff;
            s_count_ff   <= f2_count_ff;
            s_base_ff    <= f2_base_ff;
            s_j_ff       <= '0;
         end else begin
            s_j_ff <= s_j_ff + 5'd1;
         end
      end
   end

   // drive memory port and element issue from the sequencer
   always_comb begin
      mem_ctl.hdr_we  = s_active_ff && (s_cmd_ff == CMD_HEADER);
      mem_ctl.code_we = s_active_ff && (s_cmd_ff == CMD_CODES);
      hdr_addr        = s_blk_ff;
      code_addr       = (s_cmd_ff == CMD_CODES) ? {s_blk_ff, s_group_ff} :
                        {s_blk_ff, s_j_ff[4:3]};
      hdr_wdata       = s_hdr_ff;
      code_wdata      = s_codes_ff;
      elem.valid      = s_active_ff && s_lookup;
      elem.outside    = s_outside_ff;
      elem.last       = s_last;
      elem.index      = s_base_ff + 13'(s_j_ff);
      elem.byte_sel   = s_j_ff[2:0];
   end

endmodule

// File: src/sebd_store.sv
// Block header memory and code memory, one access each per enabled cycle, registered reads.
// Depends on sebd_pkg.
module sebd_store import sebd_pkg::*; #(
   parameter int TABLE_BLOCKS = TABLE_BLOCKS_DEFAULT,
   localparam int AW = $clog2(TABLE_BLOCKS)
) (
   input  logic                     clock,
   input  logic                     en,
   input  mem_ctl_type              mem_ctl,
   input  logic [AW-1:0]            hdr_addr,
   input  logic [AW+GROUP_BITS-1:0] code_addr,
   input  logic [31:0]              hdr_wdata,
   input  logic [63:0]              code_wdata,
   output logic [31:0]              hdr_rdata,
   output logic [63:0]              code_rdata
);

   logic [31:0] hdr_mem  [TABLE_BLOCKS];
   logic [63:0] code_mem [TABLE_BLOCKS << GROUP_BITS];
   logic [31:0] hdr_rd_ff;
   logic [63:0] code_rd_ff;

   // write on command, read every advancing cycle; hold read data while stalled
   always_ff @(posedge clock) begin
      if (en) begin
         if (mem_ctl.hdr_we) begin
            hdr_mem[hdr_addr] <= hdr_wdata;
         end
         hdr_rd_ff <= hdr_mem[hdr_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (mem_ctl.code_we) begin
            code_mem[code_addr] <= code_wdata;
         end
         code_rd_ff <= code_mem[code_addr];
      end
   end

   assign hdr_rdata  = hdr_rd_ff;
   assign code_rdata = code_rd_ff;

endmodule

// File: src/sebd_dequant.sv
// Dequant pipeline: code*scale+minimum in exact fixed point, then fp32 rounding.
// Depends on sebd_pkg and sebd_rsp_if; owns the result register and the stall.
module sebd_dequant import sebd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   output logic        en,
   input  elem_type    elem,
   input  logic [31:0] hdr_rdata,
   input  logic [63:0] code_rdata,
   sebd_rsp_if.source  rsp_if
);

   localparam int MAG_W = 49;

   typedef struct packed {
      logic        sign;
      logic [10:0] sig;
      logic [4:0]  sh;
      logic        inf;
      logic        nan;
   } half_fields_type;

   // fp16 as an integer in units of 2^-24: sig << sh
   function automatic half_fields_type split_half(input logic [15:0] h);
      half_fields_type f;
      f.sign = h[15];
      f.sig  = (h[14:10] == 5'd0) ? {1'b0, h[9:0]} : {1'b1, h[9:0]};
      f.sh   = (h[14:10] == 5'd0) ? 5'd0 : h[14:10] - 5'd1;
      f.inf  = (h[14:10] == 5'h1F) && (h[9:0] == 10'd0);
      f.nan  = (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
      return f;
   endfunction

   elem_type        p0_elem_ff;
   logic [63:0]     code_sh;
   logic [7:0]      code;
   half_fields_type scale_f;
   half_fields_type min_f;

   elem_type        p1_elem_ff;
   logic [18:0]     p1_prod_ff;
   half_fields_type p1_scale_ff;
   half_fields_type p1_min_ff;
   logic            p1_code_zero_ff;

   logic [MAG_W-1:0] pmag;
   logic [MAG_W-1:0] mmag;
   logic [MAG_W-1:0] mag;
   logic             sum_sign;
   logic             pinf;
   logic             is_nan;
   logic             is_inf;

   elem_type         p2_elem_ff;
   logic [MAG_W-1:0] p2_mag_ff;
   logic             p2_sign_ff;
   logic             p2_nan_ff;
   logic             p2_inf_ff;
   logic             p2_inf_sign_ff;

   logic [5:0]       pos;

   elem_type         p3_elem_ff;
   logic [MAG_W-1:0] p3_mag_ff;
   logic [5:0]       p3_pos_ff;
   logic             p3_sign_ff;
   logic             p3_nan_ff;
   logic             p3_inf_ff;
   logic             p3_inf_sign_ff;

   logic [5:0]       rsh;
   logic [73:0]      ext;
   logic [23:0]      kept;
   logic             guard;
   logic             sticky;
   logic             round_up;
   logic [24:0]      m25;
   logic [7:0]       exp_b;
   logic [31:0]      value;

   logic             rsp_valid_ff;
   logic [31:0]      rsp_value_ff;
   logic [12:0]      rsp_index_ff;
   logic             rsp_outside_ff;
   logic             rsp_last_ff;

   // advance the whole pipeline unless the result register is stuck
   assign en = !rsp_valid_ff || rsp_if.ready;

   // pick the code byte and split both halves
   always_comb begin
      code_sh = code_rdata >> {p0_elem_ff.byte_sel, 3'b000};
      code    = code_sh[7:0];
      scale_f = split_half(hdr_rdata[15:0]);
      min_f   = split_half(hdr_rdata[31:16]);
   end

   // align and add the exact product and minimum
   always_comb begin
      pmag = MAG_W'(p1_prod_ff) << p1_scale_ff.sh;
      mmag = MAG_W'(p1_min_ff.sig) << p1_min_ff.sh;
      if (p1_scale_ff.sign == p1_min_ff.sign) begin
         mag      = pmag + mmag;
         sum_sign = p1_scale_ff.sign;
      end else if (pmag >= mmag) begin
         mag      = pmag - mmag;
         sum_sign = p1_scale_ff.sign;
      end else begin
         mag      = mmag - pmag;
         sum_sign = p1_min_ff.sign;
      end
      // exact zero is +0 unless both terms are -0
      if (mag == '0) begin
         sum_sign = p1_scale_ff.sign && p1_min_ff.sign;
      end
      pinf   = p1_scale_ff.inf && !p1_code_zero_ff;
      is_nan = p1_scale_ff.nan || p1_min_ff.nan || (p1_scale_ff.inf && p1_code_zero_ff) ||
               (pinf && p1_min_ff.inf && (p1_scale_ff.sign != p1_min_ff.sign));
      is_inf = pinf || p1_min_ff.inf;
   end

   // leading one position
   always_comb begin
      pos = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (p2_mag_ff[i]) begin
            pos = 6'(i);
         end
      end
   end

   // normalize to 24 bits and round to nearest even
   always_comb begin
      rsh    = p3_pos_ff - 6'd23;
      ext    = {p3_mag_ff, 25'd0} >> rsh;
      kept   = ext[48:25];
      guard  = ext[24];
      sticky = |ext[23:0];
      if (p3_pos_ff <= 6'd23) begin
         kept   = 24'(p3_mag_ff << (6'd23 - p3_pos_ff));
         guard  = 1'b0;
         sticky = 1'b0;
      end
      round_up = guard && (sticky || kept[0]);
      m25      = {1'b0, kept} + 25'(round_up);
      exp_b    = 8'(p3_pos_ff) + 8'd103 + 8'(m25[24]);
      if (p3_elem_ff.outside) begin
         value = '0;
      end else if (p3_nan_ff) begin
         value = QNAN_BITS;
      end else if (p3_inf_ff) begin
         value = {p3_inf_sign_ff, 8'hFF, 23'd0};
      end else if (p3_mag_ff == '0) begin
         value = {p3_sign_ff, 31'd0};
      end else begin
         value = {p3_sign_ff, exp_b, m25[22:0]};
      end
   end

   // stage valid bits and payloads; clear the valid bits on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         p0_elem_ff.valid <= 1'b0;
         p1_elem_ff.valid <= 1'b0;
         p2_elem_ff.valid <= 1'b0;
         p3_elem_ff.valid <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else if (en) begin
         p0_elem_ff.valid <= elem.valid;
         p1_elem_ff.valid <= p0_elem_ff.valid;
         p2_elem_ff.valid <= p1_elem_ff.valid;
         p3_elem_ff.valid <= p2_elem_ff.valid;
         rsp_valid_ff     <= p3_elem_ff.valid;

         p0_elem_ff.outside  <= elem.outside;
         p0_elem_ff.last     <= elem.last;
         p0_elem_ff.index    <= elem.index;
         p0_elem_ff.byte_sel <= elem.byte_sel;

         p1_elem_ff.outside  <= p0_elem_ff.outside;
         p1_elem_ff.last     <= p0_elem_ff.last;
         p1_elem_ff.index    <= p0_elem_ff.index;
         p1_elem_ff.byte_sel <= p0_elem_ff.byte_sel;
         p1_prod_ff          <= 19'(code) * 19'(scale_f.sig);
         p1_scale_ff         <= scale_f;
         p1_min_ff           <= min_f;
         p1_code_zero_ff     <= code == 8'd0;

         p2_elem_ff.outside  <= p1_elem_ff.outside;
         p2_elem_ff.last     <= p1_elem_ff.last;
         p2_elem_ff.index    <= p1_elem_ff.index;
         p2_elem_ff.byte_sel <= p1_elem_ff.byte_sel;
         p2_mag_ff           <= mag;
         p2_sign_ff          <= sum_sign;
         p2_nan_ff           <= is_nan;
         p2_inf_ff           <= is_inf;
         p2_inf_sign_ff      <= pinf ? p1_scale_ff.sign : p1_min_ff.sign;

         p3_elem_ff.outside  <= p2_elem_ff.outside;
         p3_elem_ff.last     <= p2_elem_ff.last;
         p3_elem_ff.index    <= p2_elem_ff.index;
         p3_elem_ff.byte_sel <= p2_elem_ff.byte_sel;
         p3_mag_ff           <= p2_mag_ff;
         p3_pos_ff           <= pos;
         p3_sign_ff          <= p2_sign_ff;
         p3_nan_ff           <= p2_nan_ff;
         p3_inf_ff           <= p2_inf_ff;
         p3_inf_sign_ff      <= p2_inf_sign_ff;

         rsp_value_ff        <= value;
         rsp_index_ff        <= p3_elem_ff.index;
         rsp_outside_ff      <= p3_elem_ff.outside;
         rsp_last_ff         <= p3_elem_ff.last;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.value_bits    = rsp_value_ff;
   assign rsp_if.element_index = rsp_index_ff;
   assign rsp_if.out_of_shard  = rsp_outside_ff;
   assign rsp_if.last_in_block = rsp_last_ff;

endmodule

// File: tb/sharded_embedding_block_dequant_top_tb.sv
// Self-checking testbench for sharded_embedding_block_dequant_top.
// Depends on sebd_pkg and the channel interfaces in sebd_ifs.sv; drives a directed
// table, then random table writes, lookups and no-ops, checked against an in-bench predictor.
`timescale 1ns / 1ps

module sharded_embedding_block_dequant_top_tb;
   import sebd_pkg::*;

   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_ITEMS = 500;

   typedef struct {
      cmd_type     cmd;
      bit [19:0]   token;
      bit [7:0]    rblk;
      bit [15:0]   addr;
      bit [1:0]    grp;
      bit [15:0]   scale;
      bit [15:0]   minv;
      bit [63:0]   codes;
   } req_item_t;

   typedef struct {
      bit [31:0] value;
      bit [12:0] index;
      bit        outside;
      bit        last;
   } elem_result_t;

   // One row of the directed table; typed rows carry the value every element must show
   typedef struct {
      bit           phase;
      req_item_t    it;
      bit           typed;
      bit [31:0]    tvalue;
      bit           toutside;
   } dir_row_t;

   logic clock;
   logic reset;

   sebd_req_if req_ch ();
   sebd_rsp_if rsp_ch ();
   sebd_csr_if csr_ch ();

   sharded_embedding_block_dequant_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // Predictor state
   bit [19:0]    cfg_offset;
   bit [16:0]    cfg_rows;
   bit [13:0]    cfg_row_len;
   bit [31:0]    header_mem [int];
   bit [63:0]    code_mem [int];
   elem_result_t expected_elems [$];

   int errors;
   int cycles;
   int items_sent;
   int elems_checked;
   int lookups_in_shard;
   int lookups_outside;
   int burst_left;
   int stall_mode;
   int stall_count;

   dir_row_t dir_tab [$];

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycles,
                  expected_elems.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Receiver stall pattern, mode chosen per phase
   always @(negedge clock) begin
      stall_count <= stall_count + 1;
      case (stall_mode)
         0: begin
            rsp_ch.ready <= 1'b1;
         end
         1: begin
            rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            rsp_ch.ready <= ((stall_count % 7) < 3);
         end
      endcase
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      elem_result_t exp_e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_elems.size() == 0) begin
            $display("%0t: unexpected result value=%h index=%0d", $time,
                     rsp_ch.value_bits, rsp_ch.element_index);
            errors++;
         end else begin
            exp_e = expected_elems.pop_front();
            elems_checked++;
            if (rsp_ch.value_bits !== exp_e.value) begin
               $display("%0t: value_bits expected %h actual %h (index %0d)", $time,
                        exp_e.value, rsp_ch.value_bits, exp_e.index);
               errors++;
            end
            if (rsp_ch.element_index !== exp_e.index) begin
               $display("%0t: element_index expected %0d actual %0d", $time,
                        exp_e.index, rsp_ch.element_index);
               errors++;
            end
            if (rsp_ch.out_of_shard !== exp_e.outside) begin
               $display("%0t: out_of_shard expected %b actual %b", $time,
                        exp_e.outside, rsp_ch.out_of_shard);
               errors++;
            end
            if (rsp_ch.last_in_block !== exp_e.last) begin
               $display("%0t: last_in_block expected %b actual %b", $time,
                        exp_e.last, rsp_ch.last_in_block);
               errors++;
            end
         end
      end
   end

   // Magnitude of a half value as an integer in units of 2^-24
   function automatic longint half_to_fixed(bit [15:0] h);
      if (h[14:10] == 5'd0)
         return longint'(h[9:0]);
      return longint'({1'b1, h[9:0]}) << (h[14:10] - 1);
   endfunction

   // Dequantize one code: code*scale + minimum computed exactly, then rounded once to nearest even
   function automatic bit [31:0] dequant_value(bit [7:0] code, bit [15:0] sc, bit [15:0] mn);
      bit      prod_inf;
      longint  prod, mfix, sum, mag, rem, halfway;
      longint  mant;
      int      p, sh;
      bit      neg;
      prod_inf = 1'b0;
      if ((sc[14:10] == 5'h1F && sc[9:0] != 0) || (mn[14:10] == 5'h1F && mn[9:0] != 0))
         return QNAN_BITS;
      if (sc[14:10] == 5'h1F) begin
         if (code == 8'd0)
            return QNAN_BITS;
         prod_inf = 1'b1;
      end
      if (mn[14:10] == 5'h1F) begin
         if (prod_inf && sc[15] != mn[15])
            return QNAN_BITS;
         return {mn[15], 8'hFF, 23'd0};
      end
      if (prod_inf)
         return {sc[15], 8'hFF, 23'd0};
      prod = longint'(code) * half_to_fixed(sc);
      mfix = half_to_fixed(mn);
      sum  = (sc[15] ? -prod : prod) + (mn[15] ? -mfix : mfix);
      if (sum == 0)
         return (prod == 0 && sc[15] && mfix == 0 && mn[15]) ? 32'h8000_0000 : 32'd0;
      neg = (sum < 0);
      mag = neg ? -sum : sum;
      p = 0;
      for (int b = 0; b < 63; b++)
         if (mag[b])
            p = b;
      if (p <= 23) begin
         mant = mag << (23 - p);
      end else begin
         sh      = p - 23;
         mant    = mag >> sh;
         rem     = mag & ((longint'(1) << sh) - 1);
         halfway = longint'(1) << (sh - 1);
         if (rem > halfway || (rem == halfway && mant[0]))
            mant++;
         if (mant == (longint'(1) << 24)) begin
            mant = mant >> 1;
            p++;
         end
      end
      return {neg, 8'(p + 103), mant[22:0]};
   endfunction

   // Work out how many elements a lookup yields, whether it misses the shard, and its block
   function automatic void lookup_plan(input bit [19:0] token, input bit [7:0] rblk,
                                       output int count, output bit outside,
                                       output int blk);
      int     len, base;
      longint local_row, bpr;
      len  = (cfg_row_len > MAX_ROW_LENGTH) ? MAX_ROW_LENGTH : int'(cfg_row_len);
      base = int'(rblk) * BLOCK_SIZE;
      count = (base >= len) ? 0 : ((len - base > BLOCK_SIZE) ? BLOCK_SIZE : len - base);
      outside   = (token < cfg_offset);
      local_row = longint'(token) - longint'(cfg_offset);
      if (!outside)
         outside = (local_row >= longint'(cfg_rows));
      bpr = (longint'(len) + BLOCK_SIZE - 1) / BLOCK_SIZE;
      blk = outside ? 0 : int'((local_row * bpr + rblk) % TABLE_BLOCKS_DEFAULT);
   endfunction

   // Update the table copy or queue the lookup's expected elements
   function automatic void predict_item(req_item_t it);
      int         count, blk;
      bit         outside;
      bit [31:0]  hdr;
      bit [63:0]  word;
      elem_result_t e;
      case (it.cmd)
         CMD_HEADER: header_mem[int'(it.addr)] = {it.minv, it.scale};
         CMD_CODES:  code_mem[int'({it.addr, it.grp})] = it.codes;
         CMD_LOOKUP: begin
            lookup_plan(it.token, it.rblk, count, outside, blk);
            if (count > 0) begin
               if (outside)
                  lookups_outside++;
               else
                  lookups_in_shard++;
            end
            hdr = outside ? 32'd0 : header_mem[blk];
            for (int j = 0; j < count; j++) begin
               word      = outside ? 64'd0 : code_mem[blk * 4 + j / 8];
               e.value   = outside ? 32'd0 :
                           dequant_value(word[(j % 8) * 8 +: 8], hdr[15:0], hdr[31:16]);
               e.index   = 13'(int'(it.rblk) * BLOCK_SIZE + j);
               e.outside = outside;
               e.last    = (j == count - 1);
               expected_elems.push_back(e);
            end
         end
         default: ;
      endcase
   endfunction

   // Send one item with burst/gap pacing; typed items override the predicted values
   task automatic send_item(req_item_t it, bit typed = 1'b0, bit [31:0] tvalue = '0,
                            bit toutside = 1'b0);
      int first;
      if (burst_left == 0) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat ($urandom_range(0, 5)) @(negedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 10);
      end
      burst_left--;
      @(negedge clock);
      req_ch.valid        = 1'b1;
      req_ch.cmd          = it.cmd;
      req_ch.token_num    = it.token;
      req_ch.row_block    = it.rblk;
      req_ch.block_addr   = it.addr;
      req_ch.code_group   = it.grp;
      req_ch.scale_half   = it.scale;
      req_ch.minimum_half = it.minv;
      req_ch.codes_word   = it.codes;
      do
         @(posedge clock);
      while (!(req_ch.valid && req_ch.ready));
      first = expected_elems.size();
      predict_item(it);
      items_sent++;
      if (typed)
         for (int k = first; k < expected_elems.size(); k++) begin
            expected_elems[k].value   = tvalue;
            expected_elems[k].outside = toutside;
         end
   endtask

   // Hold the sender until every expected result has come and the block is quiet
   task automatic drain();
      @(negedge clock);
      req_ch.valid = 1'b0;
      burst_left = 0;
      wait (expected_elems.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, bit [19:0] data);
      @(negedge clock);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data  = data;
      do
         @(posedge clock);
      while (!(csr_ch.valid && csr_ch.ready));
      case (idx)
         CSR_SHARD_OFFSET: cfg_offset  = data[19:0];
         CSR_SHARD_ROWS:   cfg_rows    = data[16:0];
         default:          cfg_row_len = data[13:0];
      endcase
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic configure(bit [19:0] offset, bit [16:0] rows, bit [13:0] len);
      drain();
      csr_write(CSR_SHARD_OFFSET, offset);
      csr_write(CSR_SHARD_ROWS, 20'(rows));
      csr_write(CSR_ROW_LENGTH, 20'(len));
   endtask

   function automatic req_item_t make_item(cmd_type cmd, bit [19:0] token, bit [7:0] rblk,
                                           bit [15:0] addr, bit [1:0] grp,
                                           bit [15:0] scale, bit [15:0] minv,
                                           bit [63:0] codes);
      req_item_t it;
      it.cmd = cmd; it.token = token; it.rblk = rblk; it.addr = addr; it.grp = grp;
      it.scale = scale; it.minv = minv; it.codes = codes;
      return it;
   endfunction

   // Item of the given command with every field random
   function automatic req_item_t rand_item(cmd_type cmd);
      req_item_t it;
      it.cmd   = cmd;
      it.token = 20'($urandom);
      it.rblk  = 8'($urandom);
      it.addr  = 16'($urandom);
      it.grp   = 2'($urandom);
      it.scale = 16'($urandom);
      it.minv  = 16'($urandom);
      it.codes = {$urandom, $urandom};
      return it;
   endfunction

   function automatic void add_row(bit phase, req_item_t it, bit typed = 1'b0,
                                   bit [31:0] tvalue = '0, bit toutside = 1'b0);
      dir_row_t r;
      r.phase = phase; r.it = it; r.typed = typed; r.tvalue = tvalue; r.toutside = toutside;
      dir_tab.push_back(r);
   endfunction

   // Load any header or code group a lookup would read that was never written
   task automatic fill_block(bit [19:0] token, bit [7:0] rblk);
      int count, blk;
      bit outside;
      req_item_t it;
      lookup_plan(token, rblk, count, outside, blk);
      if (outside || count == 0)
         return;
      if (!header_mem.exists(blk)) begin
         it = rand_item(CMD_HEADER);
         it.addr = 16'(blk);
         send_item(it);
      end
      for (int g = 0; g <= (count - 1) / 8; g++)
         if (!code_mem.exists(blk * 4 + g)) begin
            it = rand_item(CMD_CODES);
            it.addr = 16'(blk);
            it.grp  = 2'(g);
            send_item(it);
         end
   endtask

   // Send about n items, table fills included
   task automatic run_random(int n);
      int     pick, bpr, len, start;
      bit [19:0] token;
      bit [7:0]  rblk;
      bit [16:0] local_row;
      req_item_t it;
      len = (cfg_row_len > MAX_ROW_LENGTH) ? MAX_ROW_LENGTH : int'(cfg_row_len);
      bpr = (len + BLOCK_SIZE - 1) / BLOCK_SIZE;
      start = items_sent;
      while (items_sent - start < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 55 && cfg_rows != 0 && bpr != 0) begin
            // well-formed lookup of a filled block
            local_row = ($urandom_range(0, 1) == 0) ? 17'($urandom_range(0, 7))
                                                    : 17'($urandom_range(0, cfg_rows - 1));
            if (local_row >= cfg_rows)
               local_row = '0;
            token = 20'(cfg_offset + local_row);
            rblk  = 8'($urandom_range(0, (bpr > 256 ? 256 : bpr) - 1));
            fill_block(token, rblk);
            it = rand_item(CMD_LOOKUP);
            it.token = token;
            it.rblk  = rblk;
            send_item(it);
         end else if (pick < 75) begin
            // lookup outside the shard, or beyond the row
            token = 20'($urandom);
            rblk  = 8'($urandom);
            if (!(token < cfg_offset || 32'(token) - 32'(cfg_offset) >= 32'(cfg_rows)))
               if (bpr < 256 && $urandom_range(0, 1))
                  rblk = 8'($urandom_range(bpr, 255));
               else
                  token = 20'(cfg_offset + cfg_rows + $urandom_range(0, 3));
            fill_block(token, rblk);
            it = rand_item(CMD_LOOKUP);
            it.token = token;
            it.rblk  = rblk;
            send_item(it);
         end else if (pick < 85) begin
            send_item(rand_item(CMD_HEADER));
         end else if (pick < 95) begin
            send_item(rand_item(CMD_CODES));
         end else begin
            send_item(rand_item(CMD_NOP));
         end
      end
   endtask

   initial begin
      int ph;
      reset = 1'b1;
      req_ch.valid = 1'b0; req_ch.cmd = CMD_NOP; req_ch.token_num = '0; req_ch.row_block = '0;
      req_ch.block_addr = '0; req_ch.code_group = '0; req_ch.scale_half = '0;
      req_ch.minimum_half = '0; req_ch.codes_word = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0; csr_ch.index = CSR_SHARD_OFFSET; csr_ch.data = '0;
      cfg_offset = '0; cfg_rows = '0; cfg_row_len = ROW_LENGTH_RESET;
      errors = 0; cycles = 0; items_sent = 0; elems_checked = 0;
      lookups_in_shard = 0; lookups_outside = 0; burst_left = 0;
      stall_mode = 0; stall_count = 0;

      // Directed: reset settings, then a wide shard with full-length rows
      add_row(1'b0, make_item(CMD_LOOKUP, 20'd5, 8'd0, '0, '0, '0, '0, '0),
              1'b1, 32'd0, 1'b1);
      add_row(1'b0, make_item(CMD_LOOKUP, 20'd5, 8'd200, '0, '0, '0, '0, '0));
      add_row(1'b0, make_item(CMD_NOP, 20'hFFFFF, 8'hFF, 16'hFFFF, 2'd3, 16'hFFFF, 16'hFFFF,
                              64'hFFFF_FFFF_FFFF_FFFF));
      add_row(1'b1, make_item(CMD_HEADER, '0, '0, 16'd0, '0, 16'h3C00, 16'h0000, '0));
      add_row(1'b1, make_item(CMD_CODES, '0, '0, 16'd0, 2'd0, '0, '0,
                              64'hFFFF_FFFF_FFFF_FFFF));
      add_row(1'b1, make_item(CMD_CODES, '0, '0, 16'd0, 2'd1, '0, '0, 64'd0));
      add_row(1'b1, make_item(CMD_CODES, '0, '0, 16'd0, 2'd2, '0, '0,
                              64'h0706_0504_0302_0100));
      add_row(1'b1, make_item(CMD_CODES, '0, '0, 16'd0, 2'd3, '0, '0,
                              64'h80FE_7F01_A55A_C33C));
      add_row(1'b1, make_item(CMD_LOOKUP, 20'd100, 8'd0, '0, '0, '0, '0, '0));
      add_row(1'b1, make_item(CMD_HEADER, '0, '0, 16'd1, '0, 16'h7E00, 16'h3C00, '0));
      add_row(1'b1, make_item(CMD_LOOKUP, 20'd100, 8'd1, '0, '0, '0, '0, '0),
              1'b1, QNAN_BITS, 1'b0);
      add_row(1'b1, make_item(CMD_HEADER, '0, '0, 16'd2, '0, 16'h7C00, 16'hFC00, '0));
      add_row(1'b1, make_item(CMD_LOOKUP, 20'd100, 8'd2, '0, '0, '0, '0, '0),
              1'b1, QNAN_BITS, 1'b0);
      add_row(1'b1, make_item(CMD_HEADER, '0, '0, 16'd3, '0, 16'h0001, 16'h8400, '0));
      add_row(1'b1, make_item(CMD_LOOKUP, 20'd100, 8'd3, '0, '0, '0, '0, '0));
      add_row(1'b1, make_item(CMD_HEADER, '0, '0, 16'd4, '0, 16'h7BFF, 16'h7BFF, '0));
      add_row(1'b1, make_item(CMD_LOOKUP, 20'd100, 8'd4, '0, '0, '0, '0, '0));
      add_row(1'b1, make_item(CMD_LOOKUP, 20'd99, 8'd0, '0, '0, '0, '0, '0),
              1'b1, 32'd0, 1'b1);
      add_row(1'b1, make_item(CMD_LOOKUP, 20'hFFFFF, 8'd255, '0, '0, '0, '0, '0),
              1'b1, 32'd0, 1'b1);
      add_row(1'b1, make_item(CMD_LOOKUP, 20'd400, 8'd255, '0, '0, '0, '0, '0));
      add_row(1'b1, make_item(CMD_LOOKUP, 20'd65635, 8'd0, '0, '0, '0, '0, '0));

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_tab[i]) begin
         if (dir_tab[i].phase && (i == 0 || !dir_tab[i - 1].phase))
            configure(20'd100, 17'd65536, 14'd8192);
         if (dir_tab[i].it.cmd == CMD_LOOKUP)
            fill_block(dir_tab[i].it.token, dir_tab[i].it.rblk);
         send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].tvalue, dir_tab[i].toutside);
      end

      // Random phases across several settings, extremes included
      for (ph = 0; ph < 7; ph++) begin
         stall_mode = ph % 3;
         case (ph)
            0: configure(20'hFFFFF, 17'd1, 14'd1);
            1: configure(20'd0, 17'd65536, 14'h3FFF);
            2: configure(20'($urandom), 17'($urandom_range(1, 300)), 14'd33);
            3: configure(20'd12345, 17'd500, 14'd0);
            4: configure(20'd0, 17'd0, 14'd8192);
            5: configure(20'($urandom), 17'($urandom_range(1, 65536)),
                         14'($urandom_range(1, 16383)));
            default: configure(20'($urandom_range(0, 1000)), 17'd64,
                               14'($urandom_range(1, 300)));
         endcase
         run_random(RANDOM_ITEMS / 7);
      end

      drain();
      $display("Sent %0d items, checked %0d results: %0d lookups in shard, %0d outside",
               items_sent, elems_checked, lookups_in_shard, lookups_outside);
      if (errors == 0 && expected_elems.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches, %0d results missing", errors, expected_elems.size());
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
src/sebd_pkg.sv
src/sebd_ifs.sv
src/sebd_issue.sv
src/sebd_store.sv
src/sebd_dequant.sv
src/sharded_embedding_block_dequant_top.sv
tb/sharded_embedding_block_dequant_top_tb.sv
